// File: rtl/pdpt_pkg.sv
// Package of the PLC delay and pulse timer: mode and register codes,
// the split reciprocals and the structs that pass between the parts.
// Depends on nothing.
package pdpt_pkg;

    localparam logic [1:0] MODE_ON_DELAY  = 2'd0;
    localparam logic [1:0] MODE_OFF_DELAY = 2'd1;
    localparam logic [1:0] MODE_PULSE     = 2'd2;

    localparam logic REG_TIMER_MODE = 1'b0;
    localparam logic REG_PRESET_MS  = 1'b1;

    // Reciprocals for exact division by constants after a pre-shift:
    // x/1000 = ((x>>3)*RECIP_125)>>36, x/60 = ((x>>2)*RECIP_15)>>N,
    // x/24 = ((x>>3)*RECIP_3)>>10.
    localparam logic [29:0] RECIP_125_S36 = 30'd549755814;
    localparam logic [21:0] RECIP_15_S25  = 22'd2236963;
    localparam logic [15:0] RECIP_15_S19  = 16'd34953;
    localparam logic [8:0]  RECIP_3_S10   = 9'd342;

    localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
    localparam logic [5:0]  SEC_PER_MIN = 6'd60;
    localparam logic [4:0]  HR_PER_DAY  = 5'd24;

    typedef struct packed {
        logic        q;
        logic [31:0] et;
    } sample_t;

    typedef struct packed {
        logic        q;
        logic [31:0] total;
        logic [9:0]  millis;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [5:0]  days;
    } result_t;

endpackage

// File: rtl/pdpt_front.sv
// Front part of the timer: configuration registers and the per-evaluation
// timer state update. Depends on pdpt_pkg.
module pdpt_front
    import pdpt_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        accept,
    input  logic        in_level,
    input  logic [15:0] elapsed_ms,
    output sample_t     sample
);

    logic [1:0]             mode_reg;
    logic [31:0]            preset_reg;
    logic [COUNT_WIDTH-1:0] run_count_reg, run_count_next;
    logic [31:0]            held_reg, held_next;
    logic                   q_bit_reg, q_bit_next;
    logic                   prev_level_reg;

    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sat;
    logic                   q_pulse;

    always_comb
    begin
        sum = {1'b0, run_count_reg} + (COUNT_WIDTH + 1)'(elapsed_ms);
        sat = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
        run_count_next = sat;
        held_next      = held_reg;
        q_bit_next     = q_bit_reg;
        q_pulse        = q_bit_reg;
        case (mode_reg)
            MODE_ON_DELAY:
            begin
                if (!in_level)
                begin
                    q_bit_next     = 1'b0;
                    run_count_next = '0;
                end
                else if (!q_bit_reg)
                begin
                    held_next = 32'(sat);
                    if (held_next >= preset_reg)
                        q_bit_next = 1'b1;
                end
            end
            MODE_OFF_DELAY:
            begin
                if (in_level)
                begin
                    q_bit_next     = 1'b1;
                    run_count_next = '0;
                end
                else if (q_bit_reg)
                begin
                    held_next = 32'(sat);
                    if (held_next >= preset_reg)
                        q_bit_next = 1'b0;
                end
            end
            MODE_PULSE:
            begin
                // retrigger on every rising edge
                if (in_level && !prev_level_reg)
                begin
                    run_count_next = '0;
                    q_pulse        = 1'b1;
                end
                q_bit_next = q_pulse;
                if (q_pulse)
                begin
                    held_next = 32'(run_count_next);
                    if (held_next >= preset_reg)
                        q_bit_next = 1'b0;
                end
            end
            default:
            begin
                run_count_next = sat;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ON_DELAY;
            preset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMER_MODE: mode_reg   <= cfg_data[1:0];
                REG_PRESET_MS:  preset_reg <= cfg_data;
                default:        preset_reg <= preset_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg  <= '0;
            held_reg       <= '0;
            q_bit_reg      <= 1'b0;
            prev_level_reg <= 1'b0;
        end
        else if (accept)
        begin
            run_count_reg  <= run_count_next;
            held_reg       <= held_next;
            q_bit_reg      <= q_bit_next;
            prev_level_reg <= in_level;
        end
    end

    assign sample.q  = q_bit_next;
    assign sample.et = held_next;

    a_on_delay_low_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == MODE_ON_DELAY && !in_level) |=> !q_bit_reg)
        else $error("on-delay with low input left the output set");

endmodule

// File: rtl/pdpt_queue.sv
// Short queue of timer samples between the front and the split pipeline.
// Depends on pdpt_pkg.
module pdpt_queue
    import pdpt_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  sample_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output sample_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sample_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               wr, rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign wr       = push && !full;
    assign rd       = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr && !rd)
                count_reg <= count_reg + 1'b1;
            else if (rd && !wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_fill_tracks_push: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill count did not follow a lone push");

endmodule

// File: rtl/pdpt_split.sv
// Back part of the timer: five-stage pipeline that splits the held elapsed
// time into days, hours, minutes, seconds and milliseconds. Depends on pdpt_pkg.
module pdpt_split
    import pdpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  sample_t in_data,
    output logic    take,
    output logic    out_valid,
    input  logic    pop,
    output result_t result
);

    typedef struct packed {
        logic        q;
        logic [31:0] et;
        logic [22:0] sec;
    } st1_t;

    typedef struct packed {
        logic        q;
        logic [31:0] et;
        logic [9:0]  millis;
        logic [5:0]  sec_lo;
        logic [16:0] mins;
    } st2_t;

    typedef struct packed {
        logic        q;
        logic [31:0] et;
        logic [9:0]  millis;
        logic [5:0]  seconds;
        logic [5:0]  min_lo;
        logic [10:0] hrs;
    } st3_t;

    typedef struct packed {
        logic        q;
        logic [31:0] et;
        logic [9:0]  millis;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hr_lo;
        logic [5:0]  days;
    } st4_t;

    st1_t    s1_reg;
    st2_t    s2_reg;
    st3_t    s3_reg;
    st4_t    s4_reg;
    result_t s5_reg;
    logic [4:0] v_reg;
    logic       adv;

    logic [58:0] prod1;
    logic [42:0] prod2;
    logic [30:0] prod3;
    logic [16:0] prod4;
    logic [32:0] sec_ms;
    logic [22:0] min_s;
    logic [16:0] hr_m;
    logic [10:0] day_h;

    // the whole pipeline moves together unless the result is held
    assign adv  = !v_reg[4] || pop;
    assign take = adv && in_valid;

    always_comb
    begin
        prod1  = 59'(in_data.et[31:3]) * 59'(RECIP_125_S36);
        prod2  = 43'(s1_reg.sec[22:2]) * 43'(RECIP_15_S25);
        sec_ms = 33'(s1_reg.sec) * 33'(MS_PER_SEC);
        prod3  = 31'(s2_reg.mins[16:2]) * 31'(RECIP_15_S19);
        min_s  = 23'(s2_reg.mins) * 23'(SEC_PER_MIN);
        prod4  = 17'(s3_reg.hrs[10:3]) * 17'(RECIP_3_S10);
        hr_m   = 17'(s3_reg.hrs) * 17'(SEC_PER_MIN);
        day_h  = 11'(s4_reg.days) * 11'(HR_PER_DAY);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg.q   <= in_data.q;
            s1_reg.et  <= in_data.et;
            s1_reg.sec <= prod1[58:36];

            s2_reg.q      <= s1_reg.q;
            s2_reg.et     <= s1_reg.et;
            s2_reg.millis <= s1_reg.et[9:0] - sec_ms[9:0];
            s2_reg.sec_lo <= s1_reg.sec[5:0];
            s2_reg.mins   <= prod2[41:25];

            s3_reg.q       <= s2_reg.q;
            s3_reg.et      <= s2_reg.et;
            s3_reg.millis  <= s2_reg.millis;
            s3_reg.seconds <= s2_reg.sec_lo - min_s[5:0];
            s3_reg.min_lo  <= s2_reg.mins[5:0];
            s3_reg.hrs     <= prod3[29:19];

            s4_reg.q       <= s3_reg.q;
            s4_reg.et      <= s3_reg.et;
            s4_reg.millis  <= s3_reg.millis;
            s4_reg.seconds <= s3_reg.seconds;
            s4_reg.minutes <= s3_reg.min_lo - hr_m[5:0];
            s4_reg.hr_lo   <= s3_reg.hrs[4:0];
            s4_reg.days    <= prod4[15:10];

            s5_reg.q       <= s4_reg.q;
            s5_reg.total   <= s4_reg.et;
            s5_reg.millis  <= s4_reg.millis;
            s5_reg.seconds <= s4_reg.seconds;
            s5_reg.minutes <= s4_reg.minutes;
            s5_reg.hours   <= s4_reg.hr_lo - day_h[4:0];
            s5_reg.days    <= s4_reg.days;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[3:0], in_valid};
    end

    assign out_valid = v_reg[4];
    assign result    = s5_reg;

    a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (s5_reg.millis < 10'd1000 && s5_reg.seconds < 6'd60 &&
                       s5_reg.minutes < 6'd60 && s5_reg.hours < 5'd24))
        else $error("time split field out of range");

    a_split_rebuilds_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (s5_reg.total == 32'(32'(s5_reg.days) * 32'd86400000 +
                       32'(s5_reg.hours) * 32'd3600000 + 32'(s5_reg.minutes) * 32'd60000 +
                       32'(s5_reg.seconds) * 32'd1000 + 32'(s5_reg.millis))))
        else $error("time split does not add back to the total");

endmodule

// File: rtl/plc_delay_and_pulse_timer.sv
// PLC delay and pulse timer: on-delay, off-delay and pulse modes.
// A result reaches the result ports after its sample passes the sample queue and the split stages s1 to s5.
// Throughput: one item per cycle while the sample queue has room, set by the state update in the front.
// The five-stage split pipeline and the sample queue let either side stall alone.
// Reset (rst_n low, asynchronous) zeroes timer state and registers, empties the sample queue and the split pipeline.
// Depends on pdpt_pkg, pdpt_front, pdpt_queue and pdpt_split.
module plc_delay_and_pulse_timer
    import pdpt_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        in_level,
    input  logic [15:0] elapsed_ms,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        q_out,
    output logic [31:0] et_total_ms,
    output logic [9:0]  et_millis,
    output logic [5:0]  et_seconds,
    output logic [5:0]  et_minutes,
    output logic [4:0]  et_hours,
    output logic [5:0]  et_days
);

    sample_t sample, queued;
    result_t result;
    logic    accept;
    logic    q_empty;
    logic    take;
    logic    out_valid;

    // an input transfer completes when the sample queue has room
    assign accept = push && !full;

    // front: advance the timer state and hand the sample on
    pdpt_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .in_level   (in_level),
        .elapsed_ms (elapsed_ms),
        .sample     (sample)
    );

    // hold samples while the split pipeline is stalled by the consumer
    pdpt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (sample),
        .full      (full),
        .pop       (take),
        .empty     (q_empty),
        .pop_data  (queued)
    );

    // back: split the held time and keep the result until its transfer
    pdpt_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_data   (queued),
        .take      (take),
        .out_valid (out_valid),
        .pop       (pop),
        .result    (result)
    );

    assign empty       = !out_valid;
    assign q_out       = result.q;
    assign et_total_ms = result.total;
    assign et_millis   = result.millis;
    assign et_seconds  = result.seconds;
    assign et_minutes  = result.minutes;
    assign et_hours    = result.hours;
    assign et_days     = result.days;

endmodule
